/* rtl/mtma_pkg.sv */
// Shared constants, types and functions of the memory-to-memory ALU machine.
package mtma_pkg;

	localparam int MEM_DEPTH  = 128;
	localparam int WORD_WIDTH = 32;
	localparam int ADDR_W     = $clog2(MEM_DEPTH);
	localparam int BYTE_W     = 8;
	localparam int PC_OUT_W   = 7;
	localparam int IN_ADDR_W  = 7;

	localparam int OPC_LSB  = 24;
	localparam int DST_LSB  = 16;
	localparam int SRC1_LSB = 8;
	localparam int SRC2_LSB = 0;

	localparam int INIT_ADDR_A = 32;
	localparam int INIT_VAL_A  = 10;
	localparam int INIT_ADDR_B = 33;
	localparam int INIT_VAL_B  = 5;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_STEP  = 2'd2;

	localparam logic [BYTE_W-1:0] OPC_ADD = 8'd1;
	localparam logic [BYTE_W-1:0] OPC_SUB = 8'd2;
	localparam logic [BYTE_W-1:0] OPC_MUL = 8'd3;
	localparam logic [BYTE_W-1:0] OPC_AND = 8'd4;

	typedef logic [ADDR_W-1:0]     addr_t;
	typedef logic [WORD_WIDTH-1:0] word_t;
	typedef logic [BYTE_W-1:0]     byte_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RDATA,
		S_FETCH,
		S_OP1,
		S_OP2,
		S_RESP
	} state_t;

	typedef struct packed {
		logic  en;
		logic  we;
		addr_t addr;
		word_t wdata;
	} mem_req_t;

	typedef struct packed {
		byte_t opc;
		byte_t dst;
		byte_t src2;
	} inst_t;

	typedef struct packed {
		logic signed [WORD_WIDTH-1:0] read_data;
		logic signed [WORD_WIDTH-1:0] result_value;
		byte_t                        result_address;
		logic [PC_OUT_W-1:0]          program_counter;
		logic                         address_error;
	} rsp_t;

	function automatic logic byte_in_range(input byte_t a);
		return 9'(a) < 9'(MEM_DEPTH);
	endfunction

	function automatic logic in_addr_in_range(input logic [IN_ADDR_W-1:0] a);
		return 9'(a) < 9'(MEM_DEPTH);
	endfunction

	function automatic word_t reset_word(input addr_t a);
		word_t w;
		w = '0;
		if (9'(a) == 9'(INIT_ADDR_A))
			w = WORD_WIDTH'(INIT_VAL_A);
		else if (9'(a) == 9'(INIT_ADDR_B))
			w = WORD_WIDTH'(INIT_VAL_B);
		return w;
	endfunction

	function automatic word_t alu(input word_t x, input word_t y, input byte_t opc);
		word_t r;
		unique case (opc)
			OPC_ADD: r = x + y;
			OPC_SUB: r = x - y;
			OPC_MUL: r = x * y;
			OPC_AND: r = x & y;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/mtma_req_if.sv */
// Request channel: mode, address and write data with valid/ready.
interface mtma_req_if;
	logic                                   valid;
	logic                                   ready;
	logic [1:0]                             mode;
	logic [mtma_pkg::IN_ADDR_W-1:0]         address;
	logic signed [mtma_pkg::WORD_WIDTH-1:0] data_in;

	modport source (output valid, output mode, output address, output data_in, input ready);
	modport sink (input valid, input mode, input address, input data_in, output ready);
endinterface

/* rtl/mtma_rsp_if.sv */
// Response channel: one result per request transaction with valid/ready.
interface mtma_rsp_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [mtma_pkg::WORD_WIDTH-1:0] read_data;
	logic signed [mtma_pkg::WORD_WIDTH-1:0] result_value;
	logic [mtma_pkg::BYTE_W-1:0]            result_address;
	logic [mtma_pkg::PC_OUT_W-1:0]          program_counter;
	logic                                   address_error;

	modport source (output valid, output read_data, output result_value,
		output result_address, output program_counter, output address_error, input ready);
	modport sink (input valid, input read_data, input result_value,
		input result_address, input program_counter, input address_error, output ready);
endinterface

/* rtl/mtma_word_mem.sv */
// Single-port word memory, registered read, reset image through per-word valid bits.
module mtma_word_mem (
	input  logic                clk,
	input  logic                arst_n,
	input  mtma_pkg::mem_req_t  req,
	output mtma_pkg::word_t     rdata
);

	mtma_pkg::word_t mem_q [mtma_pkg::MEM_DEPTH];
	logic [mtma_pkg::MEM_DEPTH-1:0] vld_q;
	mtma_pkg::word_t raw_s1;
	mtma_pkg::addr_t raddr_s1;
	logic            rvld_s1;

	always_ff @(posedge clk) begin
		if (req.en && req.we)
			mem_q[req.addr] <= req.wdata;
		if (req.en && !req.we)
			raw_s1 <= mem_q[req.addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rvld_s1  <= 1'b0;
			raddr_s1 <= '0;
		end else if (req.en) begin
			if (req.we) begin
				vld_q[req.addr] <= 1'b1;
			end else begin
				rvld_s1  <= vld_q[req.addr];
				raddr_s1 <= req.addr;
			end
		end
	end

	assign rdata = rvld_s1 ? raw_s1 : mtma_pkg::reset_word(raddr_s1);

endmodule

/* rtl/mem_to_mem_alu_machine.sv */
// Top level of the memory-to-memory ALU machine: sequencer around one word memory.
//
//  channel | dir | transaction
//  --------+-----+---------------------------------------------------------------
//  req     | in  | mode, address, data_in: write word, read word or one step
//  rsp     | out | read_data, result_value, result_address, program_counter, error
//
// Requests: a write ends in idle, a read in S_RDATA, a step in S_OP2 (in S_FETCH when an
// operand address is out of range); every memory access takes the single port.
// A finished result waits in the output register; a second one waits in a hold
// register and the sequencer stalls until the output register frees.
// Reset clears the program counter and the per-word valid bits; unwritten words
// read as the reset image. No clearing pass is needed.
module mem_to_mem_alu_machine (
	input logic         clk,
	input logic         arst_n,
	mtma_req_if.sink    req,
	mtma_rsp_if.source  rsp
);

	mtma_pkg::state_t   state_q, state_d;
	mtma_pkg::addr_t    pc_q, pc_d;
	mtma_pkg::mem_req_t mem_req;
	mtma_pkg::word_t    mem_rdata;
	mtma_pkg::inst_t    inst_q;
	mtma_pkg::word_t    op1_q;
	logic               rd_ok_q;
	mtma_pkg::rsp_t     out_q, hold_q, res;
	logic               out_v_q;
	logic               done;
	logic               out_free;
	logic               out_load;
	logic               hold_load;
	logic               acc;
	mtma_pkg::byte_t    f_opc, f_dst, f_src1, f_src2;
	logic               f_err;

	mtma_word_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rdata  (mem_rdata)
	);

	assign acc      = req.valid && req.ready;
	assign out_free = !out_v_q || rsp.ready;

	assign f_opc  = mem_rdata[mtma_pkg::OPC_LSB  +: mtma_pkg::BYTE_W];
	assign f_dst  = mem_rdata[mtma_pkg::DST_LSB  +: mtma_pkg::BYTE_W];
	assign f_src1 = mem_rdata[mtma_pkg::SRC1_LSB +: mtma_pkg::BYTE_W];
	assign f_src2 = mem_rdata[mtma_pkg::SRC2_LSB +: mtma_pkg::BYTE_W];
	assign f_err  = !mtma_pkg::byte_in_range(f_dst) || !mtma_pkg::byte_in_range(f_src1)
		|| !mtma_pkg::byte_in_range(f_src2);

	always_comb begin
		state_d   = state_q;
		pc_d      = pc_q;
		mem_req   = '0;
		done      = 1'b0;
		req.ready = 1'b0;
		res       = '0;
		res.program_counter = mtma_pkg::PC_OUT_W'(pc_q);

		unique case (state_q)
			mtma_pkg::S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					unique case (req.mode)
						mtma_pkg::MODE_WRITE: begin
							mem_req.en    = mtma_pkg::in_addr_in_range(req.address);
							mem_req.we    = 1'b1;
							mem_req.addr  = mtma_pkg::ADDR_W'(req.address);
							mem_req.wdata = req.data_in;
							done          = 1'b1;
						end
						mtma_pkg::MODE_READ: begin
							mem_req.en   = 1'b1;
							mem_req.addr = mtma_pkg::ADDR_W'(req.address);
							state_d      = mtma_pkg::S_RDATA;
						end
						mtma_pkg::MODE_STEP: begin
							mem_req.en   = 1'b1;
							mem_req.addr = pc_q;
							pc_d = (pc_q == mtma_pkg::ADDR_W'(mtma_pkg::MEM_DEPTH - 1)) ?
								'0 : pc_q + 1'b1;
							res.program_counter = mtma_pkg::PC_OUT_W'(pc_d);
							state_d = mtma_pkg::S_FETCH;
						end
						default: done = 1'b1;
					endcase
				end
			end
			mtma_pkg::S_RDATA: begin
				res.read_data = rd_ok_q ? mem_rdata : '0;
				done          = 1'b1;
			end
			mtma_pkg::S_FETCH: begin
				res.result_address = f_dst;
				if (f_err) begin
					res.address_error = 1'b1;
					done              = 1'b1;
				end else begin
					mem_req.en   = 1'b1;
					mem_req.addr = mtma_pkg::ADDR_W'(f_src1);
					state_d      = mtma_pkg::S_OP1;
				end
			end
			mtma_pkg::S_OP1: begin
				mem_req.en   = 1'b1;
				mem_req.addr = mtma_pkg::ADDR_W'(inst_q.src2);
				state_d      = mtma_pkg::S_OP2;
			end
			mtma_pkg::S_OP2: begin
				res.result_value   = mtma_pkg::alu(op1_q, mem_rdata, inst_q.opc);
				res.result_address = inst_q.dst;
				mem_req.en    = 1'b1;
				mem_req.we    = 1'b1;
				mem_req.addr  = mtma_pkg::ADDR_W'(inst_q.dst);
				mem_req.wdata = res.result_value;
				done          = 1'b1;
			end
			mtma_pkg::S_RESP: begin
				if (out_free)
					state_d = mtma_pkg::S_IDLE;
			end
			default: state_d = mtma_pkg::S_IDLE;
		endcase

		out_load  = 1'b0;
		hold_load = 1'b0;
		if (done) begin
			if (out_free) begin
				out_load = 1'b1;
				state_d  = mtma_pkg::S_IDLE;
			end else begin
				hold_load = 1'b1;
				state_d   = mtma_pkg::S_RESP;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtma_pkg::S_IDLE;
			pc_q    <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
			if (out_load || (state_q == mtma_pkg::S_RESP && out_free))
				out_v_q <= 1'b1;
			else if (rsp.ready)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc)
			rd_ok_q <= mtma_pkg::in_addr_in_range(req.address);
		if (state_q == mtma_pkg::S_FETCH) begin
			inst_q.opc  <= f_opc;
			inst_q.dst  <= f_dst;
			inst_q.src2 <= f_src2;
		end
		if (state_q == mtma_pkg::S_OP1)
			op1_q <= mem_rdata;
		if (out_load)
			out_q <= res;
		else if (state_q == mtma_pkg::S_RESP && out_free)
			out_q <= hold_q;
		if (hold_load)
			hold_q <= res;
	end

	assign rsp.valid           = out_v_q;
	assign rsp.read_data       = out_q.read_data;
	assign rsp.result_value    = out_q.result_value;
	assign rsp.result_address  = out_q.result_address;
	assign rsp.program_counter = out_q.program_counter;
	assign rsp.address_error   = out_q.address_error;

	// pc moves only after an accepted step
	a_pc_on_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(pc_q) |-> $past(req.valid && req.ready && req.mode == mtma_pkg::MODE_STEP))
		else $error("pc changed without a step");

	// hold state is entered only while the output register is occupied
	a_resp_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mtma_pkg::S_RESP |-> out_v_q)
		else $error("hold state with empty output register");

	// memory writes come from a write request or the write-back of a step
	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_req.en && mem_req.we) |->
			(acc && req.mode == mtma_pkg::MODE_WRITE) || state_q == mtma_pkg::S_OP2)
		else $error("unexpected memory write");

	// a read request enters its read data phase in the cycle after it is accepted
	a_read_turn: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.mode == mtma_pkg::MODE_READ) |=> state_q == mtma_pkg::S_RDATA)
		else $error("read data phase missed");

endmodule
